FILE: sv/cpss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table for the cubic phase synthesizer.
package cpss_pkg;

  // Frame and track store geometry
  localparam int FRAME_LEN    = 512;
  localparam int FRAME_AW     = $clog2(FRAME_LEN);
  localparam int MAX_PARTIALS = 512;
  localparam int PART_AW      = $clog2(MAX_PARTIALS);

  // Field widths
  localparam int FREQ_W   = 24;
  localparam int AMP_W    = 16;
  localparam int PHASE_W  = 16;
  localparam int SR_W     = 18;
  localparam int SAMPLE_W = 24;
  localparam int ACC_W    = 32;
  localparam int PREV_W   = FREQ_W + AMP_W + PHASE_W;

  localparam logic [SR_W-1:0] SR_RESET = 18'd44100;

  // Frequency to turns per sample: {frequency, 24 zero bits} / sample_rate
  localparam int DVD_W = FREQ_W + 24;
  localparam int DVS_W = SR_W;

  // Radians (Q4.12) to Q32 turns: floor(phase * K / 2^26)
  localparam int PHI_W = 34;
  localparam int MUL_W = 61;
  localparam logic signed [MUL_W-1:0] RAD_TURN_K = 61'sd11199533475044;
  localparam int RAD_SH = 26;

  // Phase accumulator extension bits (Q58 turns) and coefficient shifts
  localparam int EXT_BITS = 26;
  localparam int ALPHA_SH = EXT_BITS - 2 * FRAME_AW;
  localparam int BETA_SH  = 3 * FRAME_AW - EXT_BITS;

  // Amplitude ramp and product widths
  localparam int NUM_W     = AMP_W + FRAME_AW + 1;
  localparam int SIN_W     = 17;
  localparam int PROD_W    = NUM_W + SIN_W;
  localparam int CONTRIB_W = PROD_W - (FRAME_AW + 9);

  // Sine table
  localparam int SIN_AW = 11;
  typedef logic [15:0] sine_tab_t [0:1024];

  typedef enum logic [1:0] {
    KIND_PARTIAL   = 2'd0,
    KIND_END_FRAME = 2'd1,
    KIND_READ      = 2'd2
  } kind_e;

  // Start values handed to the oscillator
  typedef struct packed {
    logic [63:0]      p0;
    logic [63:0]      d1;
    logic [63:0]      d2;
    logic [63:0]      d3;
    logic [AMP_W-1:0] amp;
    logic [AMP_W-1:0] pamp;
  } osc_init_t;

  // Accumulator requests coming back from the oscillator
  typedef struct packed {
    logic                 rd_v;
    logic [FRAME_AW-1:0]  rd_idx;
    logic                 wr_v;
    logic [FRAME_AW-1:0]  wr_idx;
    logic [CONTRIB_W-1:0] contrib;
    logic                 last;
  } osc_req_t;

  // Build the Q15 quarter-wave table from the odd Q30 polynomial
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    int          k;
    for (k = 0; k <= 1024; k++) begin
      u  = 64'(k) << 20;
      u2 = (u * u) >> 30;
      t  = 64'd172274;
      t  = 64'd5026995 - ((u2 * t) >> 30);
      t  = 64'd85569306 - ((u2 * t) >> 30);
      t  = 64'd693598668 - ((u2 * t) >> 30);
      t  = 64'd1686629713 - ((u2 * t) >> 30);
      s  = ((u * t) >> 30) + (64'd1 << 14);
      s  = s >> 15;
      if (s > 64'd32768) begin
        s = 64'd32768;
      end
      tab[k] = 16'(s);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: sv/cpss_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read data.
module cpss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cpss_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for frequency to turns conversion.
module cpss_div
  import cpss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = !diff[DVS_W+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W:0] : rem_sh;
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/cpss_osc.sv
`timescale 1ns / 1ps
// Cubic phase oscillator: forward-difference phase, sine lookup and amplitude ramp per sample.
module cpss_osc
  import cpss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  osc_init_t init_i,
  output osc_req_t  req_o
);

  logic                       run_q, run_d;
  logic [FRAME_AW-1:0]        cnt_q, cnt_d;
  logic [63:0]                p_q, p_d, d1_q, d1_d, d2_q, d2_d, d3_q, d3_d;
  logic signed [NUM_W-1:0]    num_q, num_d;
  logic signed [AMP_W:0]      dlt_q, dlt_d;

  logic                       s1_v_q, s2_v_q, s3_v_q;
  logic [FRAME_AW-1:0]        s1_idx_q, s2_idx_q, s3_idx_q;
  logic [SIN_AW-1:0]          s1_addr_q;
  logic                       s1_neg_q, s2_neg_q;
  logic signed [NUM_W-1:0]    s1_num_q, s2_num_q;
  logic [15:0]                s2_rom_q;
  logic [CONTRIB_W-1:0]       s3_c_q;

  logic [12:0]                rnd;
  logic [11:0]                idx;
  logic [SIN_AW-1:0]          addr;
  logic signed [SIN_W-1:0]    sgn;
  logic signed [PROD_W-1:0]   prod;
  logic signed [AMP_W:0]      dlt0;

  // Round the phase to 1/4096 turn and fold into the quarter-wave table
  always_comb begin
    rnd  = p_q[57:45] + 13'd1;
    idx  = rnd[12:1];
    addr = idx[10] ? (SIN_AW'(1024) - {1'b0, idx[9:0]}) : {1'b0, idx[9:0]};
  end

  // Start a frame sweep or advance the difference registers
  always_comb begin
    dlt0  = signed'({1'b0, init_i.amp}) - signed'({1'b0, init_i.pamp});
    run_d = run_q;
    cnt_d = cnt_q;
    p_d   = p_q;
    d1_d  = d1_q;
    d2_d  = d2_q;
    d3_d  = d3_q;
    num_d = num_q;
    dlt_d = dlt_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      p_d   = init_i.p0;
      d1_d  = init_i.d1;
      d2_d  = init_i.d2;
      d3_d  = init_i.d3;
      num_d = signed'(NUM_W'({init_i.pamp, FRAME_AW'(0)})) + NUM_W'(dlt0);
      dlt_d = dlt0;
    end else if (run_q) begin
      cnt_d = cnt_q + 1'b1;
      p_d   = p_q + d1_q;
      d1_d  = d1_q + d2_q;
      d2_d  = d2_q + d3_q;
      num_d = num_q + NUM_W'(dlt_q);
      if (cnt_q == FRAME_AW'(FRAME_LEN - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  // Sign the table value and scale by the ramped amplitude
  always_comb begin
    sgn  = s2_neg_q ? -signed'({1'b0, s2_rom_q}) : signed'({1'b0, s2_rom_q});
    prod = PROD_W'(s2_num_q) * PROD_W'(sgn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      s1_v_q <= run_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    p_q       <= p_d;
    d1_q      <= d1_d;
    d2_q      <= d2_d;
    d3_q      <= d3_d;
    num_q     <= num_d;
    dlt_q     <= dlt_d;
    s1_idx_q  <= cnt_q;
    s1_addr_q <= addr;
    s1_neg_q  <= idx[11];
    s1_num_q  <= num_q;
    s2_idx_q  <= s1_idx_q;
    s2_rom_q  <= SINE_TAB[s1_addr_q];
    s2_neg_q  <= s1_neg_q;
    s2_num_q  <= s1_num_q;
    s3_idx_q  <= s2_idx_q;
    s3_c_q    <= prod[PROD_W-1:PROD_W-CONTRIB_W];
  end

  assign req_o.rd_v    = s2_v_q;
  assign req_o.rd_idx  = s2_idx_q;
  assign req_o.wr_v    = s3_v_q;
  assign req_o.wr_idx  = s3_idx_q;
  assign req_o.contrib = s3_c_q;
  assign req_o.last    = s3_v_q && (s3_idx_q == FRAME_AW'(FRAME_LEN - 1));

endmodule

FILE: sv/cubic_phase_sinusoid_synth.sv
`timescale 1ns / 1ps
// Top level of the cubic phase additive sinusoid synthesizer.
//
// Channel   Direction  Handshake                    Payload
// command   in         start, busy                  kind_i, partial_index_i, frequency_i,
//                                                   amplitude_i, phase_i
// result    out        strobe_o (one cycle)         sample_out_o
// config    in         cfg_valid_i, cfg_ready_o     cfg_data_i (sample rate)
//
// A partial on a later frame runs one divider pass (a second one when the track has a
// previous amplitude), the coefficient steps and one oscillator sweep of 512 samples
// with a read-modify-write of the accumulator memory. A partial on the first frame only
// updates the track store.
// After reset a clearing pass zeroes all 512 entries of the track and accumulator
// memories with busy high; configuration writes are taken at any time.
// The receiver cannot stall: each result shows for one cycle under strobe_o.
module cubic_phase_sinusoid_synth
  import cpss_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind_i,
  input  logic [PART_AW-1:0]         partial_index_i,
  input  logic [FREQ_W-1:0]          frequency_i,
  input  logic [AMP_W-1:0]           amplitude_i,
  input  logic signed [PHASE_W-1:0]  phase_i,
  output logic                       strobe_o,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [SR_W-1:0]            cfg_data_i
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PREV   = 4'd2;
  localparam logic [3:0] S_DIV_W  = 4'd3;
  localparam logic [3:0] S_DIV_W0 = 4'd4;
  localparam logic [3:0] S_C1     = 4'd5;
  localparam logic [3:0] S_C2     = 4'd6;
  localparam logic [3:0] S_C3     = 4'd7;
  localparam logic [3:0] S_C4     = 4'd8;
  localparam logic [3:0] S_C5     = 4'd9;
  localparam logic [3:0] S_LAUNCH = 4'd10;
  localparam logic [3:0] S_RUN    = 4'd11;
  localparam logic [3:0] S_RD_ACC = 4'd12;

  localparam logic signed [63:0] TWO32 = 64'sd4294967296;

  // Control state
  logic [3:0]              state_q, state_d;
  logic [FRAME_AW-1:0]     clr_q, clr_d;
  logic [SR_W-1:0]         sr_q, sr_d;
  logic                    first_q, first_d;
  logic                    outen_q, outen_d;
  logic [FRAME_AW-1:0]     rpos_q, rpos_d;
  logic                    strobe_q, strobe_d;

  // Payload
  logic [SAMPLE_W-1:0]     sample_q, sample_d;
  logic [PART_AW-1:0]      slot_q, slot_d;
  logic [FREQ_W-1:0]       f_q, f_d, pf_q, pf_d;
  logic [AMP_W-1:0]        a_q, a_d, pa_q, pa_d;
  logic [PHASE_W-1:0]      ph_q, ph_d, pp_q, pp_d;
  logic signed [PHI_W-1:0] phi_q, phi_d, phi0_q, phi0_d;
  logic [DVD_W-1:0]        w_q, w_d, w0_q, w0_d;
  logic signed [63:0]      t1_q, t1_d, pd_q, pd_d, ya_q, ya_d, y_q, y_d;
  logic signed [63:0]      t2_q, t2_d, na_q, na_d, nb_q, nb_d;
  logic signed [63:0]      alpha_q, alpha_d, beta_q, beta_d;

  logic                    accept;
  logic signed [PHASE_W-1:0] mul_op;
  logic signed [MUL_W-1:0] mul_res;
  logic signed [PHI_W-1:0] mul_phi;
  logic [31:0]             birth_lo;

  logic                    div_start, div_busy, div_done;
  logic [DVD_W-1:0]        div_quo;
  logic [DVS_W-1:0]        div_dvs;
  logic [FREQ_W-1:0]       div_f;

  logic                    prev_we, prev_re;
  logic [PART_AW-1:0]      prev_waddr;
  logic [PREV_W-1:0]       prev_wdata, prev_rdata;

  logic                    acc_we, acc_re;
  logic [FRAME_AW-1:0]     acc_waddr, acc_raddr;
  logic [ACC_W-1:0]        acc_wdata, acc_rdata;
  logic signed [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0]        acc_sat;
  logic signed [ACC_W-1:0] acc_rs;

  osc_init_t               osc_init;
  osc_req_t                osc_req;
  logic                    osc_start;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Shared radians-to-turns multiplier
  assign mul_op  = (state_q == S_PREV) ? signed'(ph_q) : signed'(pp_q);
  assign mul_res = mul_op * RAD_TURN_K;
  assign mul_phi = mul_res[PHI_W+RAD_SH-1:RAD_SH];

  // Birth case: previous phase lies one frame back, wrapped into half a turn
  assign birth_lo = 32'(phi_q) - 32'(div_quo << FRAME_AW);

  assign div_dvs = (sr_q == '0) ? DVS_W'(1) : sr_q;

  // Second divider run converts the previous frequency
  assign div_f = (state_q == S_DIV_W) ? pf_q : f_q;

  // Saturating accumulate of one oscillator contribution
  always_comb begin
    acc_rs  = signed'(acc_rdata);
    acc_sum = (ACC_W+1)'(acc_rs) + (ACC_W+1)'(signed'(osc_req.contrib));
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  // Oscillator start values from the cubic coefficients
  always_comb begin
    osc_init.p0   = 64'(phi0_q) <<< EXT_BITS;
    osc_init.d1   = (64'(w0_q) << EXT_BITS) + alpha_q + beta_q;
    osc_init.d2   = (alpha_q <<< 1) + (beta_q <<< 2) + (beta_q <<< 1);
    osc_init.d3   = (beta_q <<< 2) + (beta_q <<< 1);
    osc_init.amp  = a_q;
    osc_init.pamp = pa_q;
  end
  assign osc_start = (state_q == S_LAUNCH);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    sr_d     = sr_q;
    first_d  = first_q;
    outen_d  = outen_q;
    rpos_d   = rpos_q;
    strobe_d = 1'b0;
    sample_d = sample_q;
    slot_d   = slot_q;
    f_d      = f_q;
    a_d      = a_q;
    ph_d     = ph_q;
    pf_d     = pf_q;
    pa_d     = pa_q;
    pp_d     = pp_q;
    phi_d    = phi_q;
    phi0_d   = phi0_q;
    w_d      = w_q;
    w0_d     = w0_q;
    t1_d     = t1_q;
    pd_d     = pd_q;
    ya_d     = ya_q;
    y_d      = y_q;
    t2_d     = t2_q;
    na_d     = na_q;
    nb_d     = nb_q;
    alpha_d  = alpha_q;
    beta_d   = beta_q;

    div_start  = 1'b0;
    prev_we    = 1'b0;
    prev_waddr = slot_q;
    prev_wdata = {f_q, a_q, ph_q};
    prev_re    = 1'b0;
    acc_we     = 1'b0;
    acc_waddr  = osc_req.wr_idx;
    acc_wdata  = acc_sat;
    acc_re     = 1'b0;
    acc_raddr  = osc_req.rd_idx;

    if (cfg_valid_i) begin
      sr_d = cfg_data_i;
    end

    case (state_q)
      S_CLEAR: begin
        prev_we    = 1'b1;
        prev_waddr = PART_AW'(clr_q);
        prev_wdata = '0;
        acc_we     = 1'b1;
        acc_waddr  = clr_q;
        acc_wdata  = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == FRAME_AW'(FRAME_LEN - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          slot_d = partial_index_i;
          f_d    = frequency_i;
          a_d    = amplitude_i;
          ph_d   = phase_i;
          case (kind_i)
            KIND_PARTIAL: begin
              if (frequency_i != '0) begin
                prev_re = 1'b1;
                state_d = S_PREV;
              end
            end
            KIND_END_FRAME: begin
              if (first_q) begin
                outen_d = 1'b1;
              end
              first_d = 1'b1;
            end
            KIND_READ: begin
              if (outen_q) begin
                acc_re    = 1'b1;
                acc_raddr = rpos_q;
                state_d   = S_RD_ACC;
              end else begin
                strobe_d = 1'b1;
                sample_d = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PREV: begin
        // Take the stored track values and replace them with the new ones
        {pf_d, pa_d, pp_d} = prev_rdata;
        prev_we = 1'b1;
        if (first_q) begin
          div_start = 1'b1;
          phi_d     = mul_phi;
          state_d   = S_DIV_W;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV_W: begin
        if (div_done) begin
          w_d = div_quo;
          if (pa_q == '0) begin
            w0_d    = div_quo;
            phi0_d  = PHI_W'(signed'(birth_lo));
            state_d = S_C1;
          end else begin
            div_start = 1'b1;
            phi0_d    = mul_phi;
            state_d   = S_DIV_W0;
          end
        end
      end
      S_DIV_W0: begin
        if (div_done) begin
          w0_d    = div_quo;
          state_d = S_C1;
        end
      end
      S_C1: begin
        t1_d    = 64'(w_q) - 64'(w0_q);
        pd_d    = 64'(phi_q) - 64'(phi0_q);
        ya_d    = (64'(phi0_q) <<< 1) - (64'(phi_q) <<< 1) + TWO32;
        state_d = S_C2;
      end
      S_C2: begin
        y_d     = ya_q + signed'(64'(w0_q) << (FRAME_AW + 1)) + (t1_q <<< FRAME_AW);
        state_d = S_C3;
      end
      S_C3: begin
        // Phase error rounded to whole turns
        t2_d    = pd_q - signed'(64'(w0_q) << FRAME_AW) + ((y_q >>> 33) <<< 32);
        state_d = S_C4;
      end
      S_C4: begin
        na_d    = t2_q + (t2_q <<< 1) - (t1_q <<< FRAME_AW);
        nb_d    = (t1_q <<< FRAME_AW) - (t2_q <<< 1);
        state_d = S_C5;
      end
      S_C5: begin
        alpha_d = na_q <<< ALPHA_SH;
        beta_d  = nb_q >>> BETA_SH;
        state_d = S_LAUNCH;
      end
      S_LAUNCH: begin
        state_d = S_RUN;
      end
      S_RUN: begin
        acc_re = osc_req.rd_v;
        acc_we = osc_req.wr_v;
        if (osc_req.last) begin
          state_d = S_IDLE;
        end
      end
      S_RD_ACC: begin
        // Deliver the saturated sample, clear the entry, advance
        if (acc_rs > 32'sd8388607) begin
          sample_d = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (acc_rs < -32'sd8388608) begin
          sample_d = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
          sample_d = acc_rdata[SAMPLE_W-1:0];
        end
        strobe_d  = 1'b1;
        acc_we    = 1'b1;
        acc_waddr = rpos_q;
        acc_wdata = '0;
        rpos_d    = rpos_q + 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      sr_q     <= SR_RESET;
      first_q  <= 1'b0;
      outen_q  <= 1'b0;
      rpos_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      sr_q     <= sr_d;
      first_q  <= first_d;
      outen_q  <= outen_d;
      rpos_q   <= rpos_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    slot_q   <= slot_d;
    f_q      <= f_d;
    a_q      <= a_d;
    ph_q     <= ph_d;
    pf_q     <= pf_d;
    pa_q     <= pa_d;
    pp_q     <= pp_d;
    phi_q    <= phi_d;
    phi0_q   <= phi0_d;
    w_q      <= w_d;
    w0_q     <= w0_d;
    t1_q     <= t1_d;
    pd_q     <= pd_d;
    ya_q     <= ya_d;
    y_q      <= y_d;
    t2_q     <= t2_d;
    na_q     <= na_d;
    nb_q     <= nb_d;
    alpha_q  <= alpha_d;
    beta_q   <= beta_d;
  end

  assign strobe_o     = strobe_q;
  assign sample_out_o = signed'(sample_q);

  cpss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({div_f, 24'd0}),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  cpss_osc u_osc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (osc_start),
    .init_i  (osc_init),
    .req_o   (osc_req)
  );

  cpss_ram #(
    .WIDTH (PREV_W),
    .DEPTH (MAX_PARTIALS)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (prev_re),
    .raddr_i (partial_index_i),
    .rdata_o (prev_rdata)
  );

  cpss_ram #(
    .WIDTH (ACC_W),
    .DEPTH (FRAME_LEN)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

`ifndef SYNTHESIS
  // A result only follows a read command or the accumulator fetch
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ($past(state_q) == S_RD_ACC) ||
                 ($past(accept) && ($past(kind_i) == KIND_READ)))
    else $error("result strobe without a read");

  // The divider is never restarted mid-run
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // Output cannot be armed before the first frame has ended
  a_outen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outen_q |-> first_q)
    else $error("output enabled before first frame");

  // Oscillator writes only land during a sweep
  a_osc_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    osc_req.wr_v |-> (state_q == S_RUN))
    else $error("accumulator update outside a sweep");
`endif

endmodule
